// File: rtl/core/bcld_pkg.sv
// Shared types and constants for the block cache LRU directory.
package bcld_pkg;

    localparam int unsigned BLK_W    = 32;
    localparam int unsigned SLOT_O_W = 4;

    typedef enum logic [0:0] {
        CMD_ACCESS  = 1'b0,
        CMD_RECLAIM = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_EVICTED  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef struct packed {
        logic touch;
        logic insert;
        logic evict;
    } t_lru_op;

endpackage

// File: rtl/core/block_cache_lru_directory_core.sv
// Top level of the fully associative block cache directory with LRU ordering.
//
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_cmd, i_block_number
// result    out        o_out_valid / i_out_stall o_status, o_slot, o_evicted_block
// config    in         i_cfg_we                  i_cfg_data (device_blocks)
//
// A request is captured in the input register and resolved once the result
// can take it; the tag compare, rank update and result register load happen in the
// same cycle, and the result is then held in the result register until taken.
// A new request is taken every cycle while the result side keeps draining.
// Reset is synchronous; it empties the directory and needs no clearing pass.
// A stalled result holds the result register, and the input register then stalls.
module block_cache_lru_directory_core #(
    parameter int unsigned SLOTS      = 16,
    parameter int unsigned BLOCK_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [0:0]                     i_cmd,
    input  logic [bcld_pkg::BLK_W-1:0]     i_block_number,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [bcld_pkg::SLOT_O_W-1:0]  o_slot,
    output logic [bcld_pkg::BLK_W-1:0]     o_evicted_block,
    input  logic                           i_cfg_we,
    input  logic [bcld_pkg::BLK_W-1:0]     i_cfg_data
);

    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

    logic                            r_s1_valid;
    bcld_pkg::t_cmd                  r_s1_cmd;
    logic [bcld_pkg::BLK_W-1:0]      r_s1_blk;
    logic [bcld_pkg::BLK_W-1:0]      r_device_blocks;

    logic                            r_out_valid;
    bcld_pkg::t_status               r_status, n_status;
    logic [bcld_pkg::SLOT_O_W-1:0]   r_slot, n_slot;
    logic [bcld_pkg::BLK_W-1:0]      r_evict, n_evict;

    logic                            s1_adv;
    bcld_pkg::t_lru_op               lru_op;
    logic [SLOTS-1:0]                sel;
    logic [SLOTS-1:0]                valid_vec, hit_vec, victim_vec, free_vec;
    logic [CNT_W-1:0]                count;
    logic [BLOCK_BITS-1:0]           key, rdata;

    function automatic logic [SLOT_W-1:0] f_encode(input logic [SLOTS-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (oh[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign key        = BLOCK_BITS'(r_s1_blk);
    assign free_vec   = ~valid_vec & (valid_vec + SLOTS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_device_blocks <= '1;
        end else begin
            if (i_cfg_we) begin
                r_device_blocks <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_cmd <= bcld_pkg::t_cmd'(i_cmd);
            r_s1_blk <= i_block_number;
        end
        if (s1_adv) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_evict  <= n_evict;
        end
    end

    always_comb begin
        lru_op   = '0;
        sel      = '0;
        n_status = bcld_pkg::ST_EMPTY;
        n_slot   = '0;
        n_evict  = '0;
        if (r_s1_cmd == bcld_pkg::CMD_RECLAIM) begin
            if ((count != '0) && (|victim_vec)) begin
                sel          = victim_vec;
                lru_op.evict = s1_adv;
                n_status     = bcld_pkg::ST_EVICTED;
                n_slot       = bcld_pkg::SLOT_O_W'(f_encode(victim_vec));
                n_evict      = bcld_pkg::BLK_W'(rdata);
            end
        end else if (r_s1_blk >= r_device_blocks) begin
            n_status = bcld_pkg::ST_RANGE;
        end else if (|hit_vec) begin
            sel          = hit_vec;
            lru_op.touch = s1_adv;
            n_status     = bcld_pkg::ST_HIT;
            n_slot       = bcld_pkg::SLOT_O_W'(f_encode(hit_vec));
        end else if (|free_vec) begin
            sel           = free_vec;
            lru_op.insert = s1_adv;
            n_status      = bcld_pkg::ST_INSERTED;
            n_slot        = bcld_pkg::SLOT_O_W'(f_encode(free_vec));
        end else begin
            n_status = bcld_pkg::ST_FULL;
        end
    end

    bcld_tags #(
        .SLOTS (SLOTS),
        .TAG_W (BLOCK_BITS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (lru_op.insert),
        .i_sel   (sel),
        .i_wdata (key),
        .i_key   (key),
        .i_valid (valid_vec),
        .o_hit   (hit_vec),
        .o_rdata (rdata)
    );

    bcld_lru #(
        .SLOTS (SLOTS)
    ) u_lru (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (lru_op),
        .i_sel    (sel),
        .o_valid  (valid_vec),
        .o_count  (count),
        .o_victim (victim_vec)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_evicted_block = r_evict;

endmodule

// File: rtl/core/bcld_tags.sv
// Tag cells with parallel compare, one-hot write and one-hot read.
module bcld_tags #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned TAG_W = 32
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [SLOTS-1:0]   i_sel,
    input  logic [TAG_W-1:0]   i_wdata,
    input  logic [TAG_W-1:0]   i_key,
    input  logic [SLOTS-1:0]   i_valid,
    output logic [SLOTS-1:0]   o_hit,
    output logic [TAG_W-1:0]   o_rdata
);

    logic [TAG_W-1:0] r_tag [SLOTS];
    logic [SLOTS-1:0] match;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_we && i_sel[i]) begin
                r_tag[i] <= i_wdata;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = i_valid[i] && (r_tag[i] == i_key);
        end
    end

    // Keep only the lowest matching slot.
    assign o_hit = match & (~match + SLOTS'(1));

    always_comb begin
        o_rdata = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_sel[i]) begin
                o_rdata = o_rdata | r_tag[i];
            end
        end
    end

endmodule

// File: rtl/core/bcld_lru.sv
// Valid bits, recency ranks, occupancy count and victim selection.
module bcld_lru #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcld_pkg::t_lru_op             i_op,
    input  logic [SLOTS-1:0]              i_sel,
    output logic [SLOTS-1:0]              o_valid,
    output logic [$clog2(SLOTS+1)-1:0]    o_count,
    output logic [SLOTS-1:0]              o_victim
);

    localparam int unsigned RANK_W = $clog2(SLOTS);
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [RANK_W-1:0] r_rank [SLOTS];
    logic [RANK_W-1:0] n_rank [SLOTS];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [RANK_W-1:0] sel_rank;
    logic [SLOTS-1:0]  cand;

    always_comb begin
        sel_rank = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_sel[i]) begin
                sel_rank = sel_rank | r_rank[i];
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < SLOTS; i++) begin
            n_rank[i] = r_rank[i];
            if (i_op.touch) begin
                if (i_sel[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < sel_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (i_op.insert) begin
                if (i_sel[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (i_op.evict) begin
                if (i_sel[i]) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end
            end
        end
        if (i_op.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_op.evict) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // The least recent entry holds rank count minus one.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            cand[i] = r_valid[i] && ((CNT_W'(r_rank[i]) + CNT_W'(1)) == r_count);
        end
    end

    assign o_victim = cand & (~cand + SLOTS'(1));
    assign o_valid  = r_valid;
    assign o_count  = r_count;

endmodule

// File: tb/block_cache_lru_directory_core_test.sv
// Self-checking testbench for the block cache LRU directory core.
module block_cache_lru_directory_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_SLOTS    = 16;
    localparam int DIRECTED_N   = 24;
    localparam int POOL_N       = 24;
    localparam int PHASE_N      = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        bcld_pkg::t_status status;
        logic [3:0]        slot;
        logic [31:0]       evicted_block;
    } t_dir_result;

    typedef struct {
        bcld_pkg::t_cmd    cmd;
        logic [31:0]       blk;
        bit                typed;
        bcld_pkg::t_status status;
        logic [3:0]        slot;
        logic [31:0]       evicted_block;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [0:0]  i_cmd;
    logic [31:0] i_block_number;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;
    logic [31:0] o_evicted_block;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    // Predictor copy of the directory state.
    logic [31:0] tag_of [DIR_SLOTS];
    logic        held [DIR_SLOTS];
    logic [3:0]  age_rank [DIR_SLOTS];
    logic [4:0]  held_count;
    logic [31:0] blocks_limit;

    t_dir_result pending_results [$];
    logic [31:0] block_pool [POOL_N];
    t_stim_row   directed_rows [DIRECTED_N];

    int mismatches;
    int checked;
    int sent;
    int status_seen [6];
    int burst_left;
    int gap_max;
    int stall_pct;

    block_cache_lru_directory_core #(
        .SLOTS      (DIR_SLOTS),
        .BLOCK_BITS (bcld_pkg::BLK_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_block_number  (i_block_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_evicted_block (o_evicted_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_dir_result resolve_request(input bcld_pkg::t_cmd c,
                                                    input logic [31:0] b);
        t_dir_result r;
        int i;
        int hit_i;
        int free_i;
        int lru_i;
        logic [3:0] old_rank;
        r.status = bcld_pkg::ST_EMPTY;
        r.slot = '0;
        r.evicted_block = '0;
        hit_i = -1;
        free_i = -1;
        lru_i = -1;
        if (c == bcld_pkg::CMD_RECLAIM) begin
            for (i = 0; i < DIR_SLOTS; i++) begin
                if (lru_i < 0 && held[i] && {1'b0, age_rank[i]} == held_count - 5'd1) begin
                    lru_i = i;
                end
            end
            if (held_count != 0 && lru_i >= 0) begin
                held[lru_i] = 1'b0;
                age_rank[lru_i] = '0;
                held_count = held_count - 5'd1;
                r.status = bcld_pkg::ST_EVICTED;
                r.slot = 4'(lru_i);
                r.evicted_block = tag_of[lru_i];
            end
        end else if (b >= blocks_limit) begin
            r.status = bcld_pkg::ST_RANGE;
        end else begin
            for (i = 0; i < DIR_SLOTS; i++) begin
                if (held[i]) begin
                    if (hit_i < 0 && tag_of[i] == b) hit_i = i;
                end else if (free_i < 0) begin
                    free_i = i;
                end
            end
            if (hit_i >= 0) begin
                old_rank = age_rank[hit_i];
                for (i = 0; i < DIR_SLOTS; i++) begin
                    if (held[i] && age_rank[i] < old_rank) age_rank[i] = age_rank[i] + 4'd1;
                end
                age_rank[hit_i] = '0;
                r.status = bcld_pkg::ST_HIT;
                r.slot = 4'(hit_i);
            end else if (free_i < 0) begin
                r.status = bcld_pkg::ST_FULL;
            end else begin
                for (i = 0; i < DIR_SLOTS; i++) begin
                    if (held[i]) age_rank[i] = age_rank[i] + 4'd1;
                end
                held[free_i] = 1'b1;
                tag_of[free_i] = b;
                age_rank[free_i] = '0;
                held_count = held_count + 5'd1;
                r.status = bcld_pkg::ST_INSERTED;
                r.slot = 4'(free_i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_block();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return block_pool[$urandom_range(POOL_N - 1)];
        if (sel < 85) begin
            case ($urandom_range(4))
                0: return blocks_limit - 32'd1;
                1: return blocks_limit;
                2: return blocks_limit + 32'd1;
                3: return 32'd0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s on result %0d: got %0h, expected %0h",
                 $time, what, checked, got, want);
    endtask

    task automatic send_request(input bcld_pkg::t_cmd c, input logic [31:0] b,
                                input bit typed, input t_dir_result want);
        t_dir_result predicted;
        i_in_valid <= 1'b1;
        i_cmd <= c;
        i_block_number <= b;
        do @(posedge i_clk); while (o_in_stall);
        predicted = resolve_request(c, b);
        pending_results.push_back(typed ? want : predicted);
        sent++;
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
                burst_left = $urandom_range(20, 1);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blocks_limit = value;
    endtask

    initial begin : out_stall_gen
        int run_left;
        bit stall_now;
        run_left = 0;
        stall_now = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                run_left = $urandom_range(6, 1);
                stall_now = ($urandom_range(99) < stall_pct);
            end
            run_left--;
            i_out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_dir_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_status < 3'd6) status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", {29'd0, o_status}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status) begin
                    report_mismatch("status", {29'd0, o_status}, {29'd0, want.status});
                end
                if (o_slot != want.slot) begin
                    report_mismatch("slot", {28'd0, o_slot}, {28'd0, want.slot});
                end
                if (o_evicted_block != want.evicted_block) begin
                    report_mismatch("evicted_block", o_evicted_block, want.evicted_block);
                end
            end
            checked++;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Run exceeded %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]    phase_limit [PHASE_N];
        int             phase_items [PHASE_N];
        int             phase_reclaim [PHASE_N];
        int             phase_gap [PHASE_N];
        int             phase_stall [PHASE_N];
        t_dir_result    want;
        bcld_pkg::t_cmd c;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= bcld_pkg::CMD_ACCESS;
        i_block_number <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        for (int i = 0; i < DIR_SLOTS; i++) begin
            tag_of[i] = '0;
            held[i] = 1'b0;
            age_rank[i] = '0;
        end
        held_count = '0;
        blocks_limit = 32'hFFFF_FFFF;
        mismatches = 0;
        checked = 0;
        sent = 0;
        for (int i = 0; i < 6; i++) status_seen[i] = 0;
        burst_left = 5;
        gap_max = 4;
        stall_pct = 25;

        directed_rows = '{
            '{bcld_pkg::CMD_RECLAIM, 32'hFFFF_FFFF, 1'b1, bcld_pkg::ST_EMPTY, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 1'b1, bcld_pkg::ST_RANGE, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0000, 1'b1, bcld_pkg::ST_INSERTED, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'hFFFF_FFFE, 1'b1, bcld_pkg::ST_INSERTED, 4'd1, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0000, 1'b1, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h8000_0000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h7FFF_FFFF, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'hAAAA_AAAA, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h5555_5555, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0001, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0002, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0004, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0008, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0010, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0100, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_1000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0001_0000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0100_0000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'hF0F0_F0F0, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h1234_5678, 1'b1, bcld_pkg::ST_FULL, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'hFFFF_FFFE, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_RECLAIM, 32'h0000_0000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_RECLAIM, 32'h0F0F_0F0F, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0},
            '{bcld_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, bcld_pkg::ST_HIT, 4'd0, 32'd0}
        };

        phase_limit   = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd40, 32'h8000_0000, 32'hFFFF_FFFF};
        phase_items   = '{300, 100, 150, 400, 300, 376};
        phase_reclaim = '{25, 30, 30, 15, 40, 20};
        phase_gap     = '{6, 4, 3, 0, 8, 2};
        phase_stall   = '{30, 20, 40, 0, 50, 70};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_N; r++) begin
            want.status = directed_rows[r].status;
            want.slot = directed_rows[r].slot;
            want.evicted_block = directed_rows[r].evicted_block;
            send_request(directed_rows[r].cmd, directed_rows[r].blk,
                         directed_rows[r].typed, want);
        end

        for (int p = 0; p < PHASE_N; p++) begin
            if (p > 0) write_limit(phase_limit[p]);
            gap_max = phase_gap[p];
            stall_pct = phase_stall[p];
            for (int k = 0; k < POOL_N; k++) begin
                block_pool[k] = (blocks_limit == 0) ? $urandom : $urandom % blocks_limit;
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                c = ($urandom_range(99) < phase_reclaim[p]) ? bcld_pkg::CMD_RECLAIM
                                                            : bcld_pkg::CMD_ACCESS;
                send_request(c, pick_block(), 1'b0, want);
            end
        end

        wait_idle();
        $display("Sent %0d requests over %0d device size settings, zero and full range included.",
                 sent, PHASE_N);
        $display("Saw %0d hit, %0d inserted, %0d full, %0d range, %0d evicted, %0d empty.",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bcld_pkg.sv
rtl/core/bcld_tags.sv
rtl/core/bcld_lru.sv
rtl/core/block_cache_lru_directory_core.sv
tb/block_cache_lru_directory_core_test.sv
